>>> rtl/clcd_pkg.sv
package clcd_pkg;

    localparam int CmdW    = 4;
    localparam int ArgW    = 8;
    localparam int ByteW   = 8;
    localparam int HoldW   = 11;
    localparam int StatusW = 2;
    localparam int ColW    = 6;

    // Columns visible on one display line; shifts stay inside this window
    localparam logic [ColW-1:0] VISIBLE_COLUMNS = ColW'(20);
    localparam logic [ColW-1:0] MAX_COLUMN      = ColW'(39);

    // Request codes
    localparam logic [CmdW-1:0] CMD_BACKLIGHT   = 4'd0;
    localparam logic [CmdW-1:0] CMD_SET_LINE    = 4'd1;
    localparam logic [CmdW-1:0] CMD_CLEAR       = 4'd2;
    localparam logic [CmdW-1:0] CMD_HOME        = 4'd3;
    localparam logic [CmdW-1:0] CMD_ENTRY_ID    = 4'd4;
    localparam logic [CmdW-1:0] CMD_ENTRY_SHIFT = 4'd5;
    localparam logic [CmdW-1:0] CMD_DISPLAY     = 4'd6;
    localparam logic [CmdW-1:0] CMD_CURSOR      = 4'd7;
    localparam logic [CmdW-1:0] CMD_BLINK       = 4'd8;
    localparam logic [CmdW-1:0] CMD_SHIFT_SC    = 4'd9;
    localparam logic [CmdW-1:0] CMD_SHIFT_RL    = 4'd10;
    localparam logic [CmdW-1:0] CMD_CHAR        = 4'd11;

    // Status codes
    localparam logic [StatusW-1:0] ST_OK          = 2'd0;
    localparam logic [StatusW-1:0] ST_BAD_ARG     = 2'd1;
    localparam logic [StatusW-1:0] ST_UNSUPPORTED = 2'd2;

    // Register indexes
    localparam logic REG_SHORT_HOLD = 1'b0;
    localparam logic REG_LONG_HOLD  = 1'b1;

    // Instruction bytes and bit masks
    localparam logic [ByteW-1:0] LCD_CLEAR       = 8'h01;
    localparam logic [ByteW-1:0] LCD_HOME        = 8'h02;
    localparam logic [ByteW-1:0] LINE1_BASE      = 8'h80;
    localparam logic [ByteW-1:0] LINE2_BASE      = 8'hC0;
    localparam logic [ByteW-1:0] ENTRY_RESET     = 8'h04;
    localparam logic [ByteW-1:0] DISPLAY_RESET   = 8'h0F;
    localparam logic [ByteW-1:0] SHIFT_RESET     = 8'h10;
    localparam logic [ByteW-1:0] MASK_ENTRY_ID   = 8'h02;
    localparam logic [ByteW-1:0] MASK_ENTRY_SH   = 8'h01;
    localparam logic [ByteW-1:0] MASK_DISP_ON    = 8'h04;
    localparam logic [ByteW-1:0] MASK_CURSOR_ON  = 8'h02;
    localparam logic [ByteW-1:0] MASK_BLINK_ON   = 8'h01;
    localparam logic [ByteW-1:0] MASK_SHIFT_SC   = 8'h08;
    localparam logic [ByteW-1:0] MASK_SHIFT_RL   = 8'h04;

    localparam logic [HoldW-1:0] SHORT_HOLD_RESET = 11'd300;
    localparam logic [HoldW-1:0] LONG_HOLD_RESET  = 11'd1640;

    typedef struct packed {
        logic [HoldW-1:0] short_hold;
        logic [HoldW-1:0] long_hold;
    } t_cfg;

    typedef struct packed {
        logic               bus_write;
        logic               lcd_rs;
        logic [ByteW-1:0]   lcd_byte;
        logic [HoldW-1:0]   hold_us;
        logic               backlight_pin;
        logic [StatusW-1:0] status;
    } t_result;

    function automatic logic [ByteW-1:0] with_bit(
        input logic [ByteW-1:0] v,
        input logic [ByteW-1:0] mask,
        input logic             on
    );
        return on ? (v | mask) : (v & ~mask);
    endfunction

endpackage

>>> rtl/char_lcd_command_translator.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser: command[3:0]; tdata: arg[7:0]
// m_axis    out  tuser: lcd_rs; tdata: bus_write, lcd_byte, hold_us, backlight_pin, status
// apb       in   reg 0 short_hold_us at 0x0, reg 1 long_hold_us at 0x4
//
// One request per clock while the output is not stalled. A beat accepted into the input
// register is read there by the translation logic against the shadow registers, and its
// result is registered in the output register once that register is free to take it.
// Synchronous reset clears both stage valids and resets all shadow state and hold registers.
// A stalled output holds its beat; the input register fills behind it and s_axis_tready
// drops until m_axis_tready returns.
module char_lcd_command_translator #(
    parameter logic [clcd_pkg::ColW-1:0] VISIBLE_COLUMNS = clcd_pkg::VISIBLE_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] arg
    input  logic [3:0]  s_axis_tuser,  // [3:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [0] bus_write, [8:1] lcd_byte, [19:9] hold_us,
                                       // [20] backlight_pin, [22:21] status, [23] zero
    output logic [0:0]  m_axis_tuser,  // [0] lcd_rs
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                          r_in_vld;
    logic [clcd_pkg::CmdW-1:0]     r_in_cmd;
    logic [clcd_pkg::ArgW-1:0]     r_in_arg;
    logic                          r_out_vld;
    clcd_pkg::t_result             r_out;
    clcd_pkg::t_result             w_res;
    clcd_pkg::t_cfg                w_cfg;
    logic                          w_out_free;
    logic                          w_fire;
    logic                          w_take;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_fire        = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    clcd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    clcd_core #(
        .VISIBLE_COLUMNS (VISIBLE_COLUMNS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_cmd    (r_in_cmd),
        .i_arg    (r_in_arg),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_cmd <= s_axis_tuser;
            r_in_arg <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.lcd_rs;
    assign m_axis_tdata  = {1'b0, r_out.status, r_out.backlight_pin, r_out.hold_us,
                            r_out.lcd_byte, r_out.bus_write};

endmodule

>>> rtl/clcd_cfg_regs.sv
module clcd_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output clcd_pkg::t_cfg     o_cfg
);

    logic [clcd_pkg::HoldW-1:0] r_short_hold;
    logic [clcd_pkg::HoldW-1:0] r_long_hold;
    logic                       w_wr;
    logic                       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hold <= clcd_pkg::SHORT_HOLD_RESET;
            r_long_hold  <= clcd_pkg::LONG_HOLD_RESET;
        end else if (w_wr) begin
            if (w_idx == clcd_pkg::REG_SHORT_HOLD) begin
                r_short_hold <= pwdata[clcd_pkg::HoldW-1:0];
            end else begin
                r_long_hold <= pwdata[clcd_pkg::HoldW-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == clcd_pkg::REG_SHORT_HOLD) begin
            prdata[clcd_pkg::HoldW-1:0] = r_short_hold;
        end else begin
            prdata[clcd_pkg::HoldW-1:0] = r_long_hold;
        end
    end

    assign o_cfg.short_hold = r_short_hold;
    assign o_cfg.long_hold  = r_long_hold;

endmodule

>>> rtl/clcd_core.sv
module clcd_core #(
    parameter logic [clcd_pkg::ColW-1:0] VISIBLE_COLUMNS = clcd_pkg::VISIBLE_COLUMNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [clcd_pkg::CmdW-1:0]     i_cmd,
    input  logic [clcd_pkg::ArgW-1:0]     i_arg,
    input  clcd_pkg::t_cfg                i_cfg,
    output clcd_pkg::t_result             o_result
);

    logic [clcd_pkg::ByteW-1:0] r_entry, n_entry;
    logic [clcd_pkg::ByteW-1:0] r_disp, n_disp;
    logic [clcd_pkg::ByteW-1:0] r_shift, n_shift;
    logic                       r_line, n_line;
    logic [clcd_pkg::ColW-1:0]  r_col, n_col;
    logic                       r_bl, n_bl;

    logic                         w_flag_ok;
    logic                         w_write;
    logic                         w_rs;
    logic [clcd_pkg::ByteW-1:0]   w_byte;
    logic [clcd_pkg::HoldW-1:0]   w_hold;
    logic [clcd_pkg::StatusW-1:0] w_status;

    assign w_flag_ok = (i_arg[clcd_pkg::ArgW-1:1] == '0);

    always_comb begin
        n_entry  = r_entry;
        n_disp   = r_disp;
        n_shift  = r_shift;
        n_line   = r_line;
        n_col    = r_col;
        n_bl     = r_bl;
        w_write  = 1'b0;
        w_rs     = 1'b0;
        w_byte   = '0;
        w_hold   = '0;
        w_status = clcd_pkg::ST_OK;
        unique case (i_cmd)
            clcd_pkg::CMD_BACKLIGHT: begin
                // pin is active low for the light
                if (!w_flag_ok) w_status = clcd_pkg::ST_BAD_ARG;
                else            n_bl = ~i_arg[0];
            end
            clcd_pkg::CMD_SET_LINE: begin
                if (i_arg != 8'd1 && i_arg != 8'd2) begin
                    w_status = clcd_pkg::ST_BAD_ARG;
                end else begin
                    n_line  = i_arg[1];
                    w_write = 1'b1;
                    w_byte  = (i_arg[1] ? clcd_pkg::LINE2_BASE : clcd_pkg::LINE1_BASE)
                              + {2'b00, r_col};
                    w_hold  = i_cfg.short_hold;
                end
            end
            clcd_pkg::CMD_CLEAR: begin
                w_write = 1'b1;
                w_byte  = clcd_pkg::LCD_CLEAR;
                w_hold  = i_cfg.long_hold;
                n_col   = '0;
            end
            clcd_pkg::CMD_HOME: begin
                w_write = 1'b1;
                w_byte  = clcd_pkg::LCD_HOME;
                w_hold  = i_cfg.long_hold;
            end
            clcd_pkg::CMD_ENTRY_ID, clcd_pkg::CMD_ENTRY_SHIFT: begin
                if (!w_flag_ok) begin
                    w_status = clcd_pkg::ST_BAD_ARG;
                end else begin
                    n_entry = clcd_pkg::with_bit(r_entry,
                        (i_cmd == clcd_pkg::CMD_ENTRY_ID) ? clcd_pkg::MASK_ENTRY_ID
                                                          : clcd_pkg::MASK_ENTRY_SH,
                        i_arg[0]);
                    w_write = 1'b1;
                    w_byte  = n_entry;
                    w_hold  = i_cfg.short_hold;
                end
            end
            clcd_pkg::CMD_DISPLAY, clcd_pkg::CMD_CURSOR, clcd_pkg::CMD_BLINK: begin
                if (!w_flag_ok) begin
                    w_status = clcd_pkg::ST_BAD_ARG;
                end else begin
                    n_disp = clcd_pkg::with_bit(r_disp,
                        (i_cmd == clcd_pkg::CMD_DISPLAY) ? clcd_pkg::MASK_DISP_ON :
                        (i_cmd == clcd_pkg::CMD_CURSOR)  ? clcd_pkg::MASK_CURSOR_ON
                                                         : clcd_pkg::MASK_BLINK_ON,
                        i_arg[0]);
                    w_write = 1'b1;
                    w_byte  = n_disp;
                    w_hold  = i_cfg.short_hold;
                end
            end
            clcd_pkg::CMD_SHIFT_SC: begin
                if (!w_flag_ok) begin
                    w_status = clcd_pkg::ST_BAD_ARG;
                end else begin
                    n_shift = clcd_pkg::with_bit(r_shift, clcd_pkg::MASK_SHIFT_SC, i_arg[0]);
                    w_write = 1'b1;
                    w_byte  = n_shift;
                    w_hold  = i_cfg.short_hold;
                end
            end
            clcd_pkg::CMD_SHIFT_RL: begin
                if (!w_flag_ok) begin
                    w_status = clcd_pkg::ST_BAD_ARG;
                end else begin
                    // R/L bit updates even when the move is dropped at an edge
                    n_shift = clcd_pkg::with_bit(r_shift, clcd_pkg::MASK_SHIFT_RL, i_arg[0]);
                    if (!i_arg[0]) begin
                        if (r_col != '0 && r_col < VISIBLE_COLUMNS) begin
                            w_write = 1'b1;
                            w_byte  = n_shift;
                            w_hold  = i_cfg.short_hold;
                            n_col   = r_col - 1'b1;
                        end
                    end else begin
                        if (r_col < VISIBLE_COLUMNS - 1'b1) begin
                            w_write = 1'b1;
                            w_byte  = n_shift;
                            w_hold  = i_cfg.short_hold;
                            n_col   = r_col + 1'b1;
                        end
                    end
                end
            end
            clcd_pkg::CMD_CHAR: begin
                w_write = 1'b1;
                w_rs    = 1'b1;
                w_byte  = i_arg;
                w_hold  = i_cfg.short_hold;
                if (r_col < clcd_pkg::MAX_COLUMN) n_col = r_col + 1'b1;
            end
            default: begin
                w_status = clcd_pkg::ST_UNSUPPORTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= clcd_pkg::ENTRY_RESET;
            r_disp  <= clcd_pkg::DISPLAY_RESET;
            r_shift <= clcd_pkg::SHIFT_RESET;
            r_line  <= 1'b0;
            r_col   <= '0;
            r_bl    <= 1'b0;
        end else if (i_fire) begin
            r_entry <= n_entry;
            r_disp  <= n_disp;
            r_shift <= n_shift;
            r_line  <= n_line;
            r_col   <= n_col;
            r_bl    <= n_bl;
        end
    end

    // current line is kept as shadow state; the address path uses the requested line
    assign o_result.bus_write     = w_write;
    assign o_result.lcd_rs        = w_rs;
    assign o_result.lcd_byte      = w_byte;
    assign o_result.hold_us       = w_hold;
    assign o_result.backlight_pin = n_bl | (r_line & 1'b0);
    assign o_result.status        = w_status;

endmodule

>>> rtl/clcd_checker.sv
module clcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // no bus write: byte, hold and rs read zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
            m_axis_tdata[19:1] == 19'd0 && m_axis_tuser == 1'b0)
        else $error("write fields not zero without a bus write");

    // an error status never comes with a bus write
    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22:21] != 2'd0 |-> !m_axis_tdata[0])
        else $error("bus write with error status");

    // a data-register write is always a good character
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == 1'b1 |->
            m_axis_tdata[0] && m_axis_tdata[22:21] == 2'd0)
        else $error("data write with bad status");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind char_lcd_command_translator clcd_checker u_clcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
